// File: hw/rtl/spgemm_hash_accumulator_unit_assert.svh
// Assertion macros shared by the accumulator RTL.
`ifndef SPGEMM_HASH_ACCUMULATOR_UNIT_ASSERT_SVH
`define SPGEMM_HASH_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SHACC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shacc same-cycle check failed");

// Next-cycle implication.
`define SHACC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shacc next-cycle check failed");

`endif

// File: hw/rtl/shacc_pkg.sv
// Shared types and constants of the sparse column hash accumulator.
package shacc_pkg;

  // Floating point unit operations
  typedef enum logic {
    FP_MUL,
    FP_ADD
  } fp_op_t;

  // Floating point unit sequencer states
  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ALIGN,
    F_LNORM,
    F_RSH,
    F_ROUND,
    F_DONE
  } fpu_state_t;

  // Accumulator controller states
  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_PROBE,
    C_CMP,
    C_ADD,
    C_SCAN,
    C_EMIT
  } ctl_state_t;

  // Configuration register map
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_DIRECT     = 2'd0;
  localparam logic [1:0] REG_SIZE_LOG2  = 2'd1;
  localparam logic [1:0] REG_COUNT_ONLY = 2'd2;

  // Double precision constants
  localparam logic [10:0] EXP_MAX     = 11'h7FF;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO    = 64'h8000_0000_0000_0000;

  // Hash multiplier for the home slot
  localparam logic [6:0] HASH_MULT = 7'd107;

endpackage

// File: hw/rtl/shacc_table.sv
// Entry memory: row and running sum per slot, registered read.
module shacc_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/shacc_fpu.sv
// Multi-cycle double precision multiply and add, round to nearest even.
module shacc_fpu (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  shacc_pkg::fp_op_t op,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic             done,
  output logic [63:0]      result
);
  import shacc_pkg::*;

  fpu_state_t         st, st_next;
  logic               sgn;
  logic signed [13:0] be;
  logic [105:0]       w;
  logic               stk;
  logic [52:0]        sig_a, sig_b;
  logic [1:0]         pp_k;
  logic [63:0]        small_m;
  logic [10:0]        dsh;
  logic               sub;

  // Operand decode
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [10:0] ea, eb;
  logic        special;
  logic [63:0] spec_val;

  always_comb begin
    a_nan  = (a[62:52] == EXP_MAX) && (a[51:0] != '0);
    b_nan  = (b[62:52] == EXP_MAX) && (b[51:0] != '0);
    a_inf  = (a[62:52] == EXP_MAX) && (a[51:0] == '0);
    b_inf  = (b[62:52] == EXP_MAX) && (b[51:0] == '0);
    a_zero = (a[62:0] == '0);
    b_zero = (b[62:0] == '0);
    ea = (a[62:52] == '0) ? 11'd1 : a[62:52];
    eb = (b[62:52] == '0) ? 11'd1 : b[62:52];
    special  = 1'b1;
    spec_val = '0;
    if (a_nan) begin
      spec_val = a | QUIET_BIT;
    end else if (b_nan) begin
      spec_val = b | QUIET_BIT;
    end else if (op == FP_MUL) begin
      if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        spec_val = DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
        spec_val = {a[63] ^ b[63], EXP_MAX, 52'b0};
      end else begin
        special = 1'b0;
      end
    end else begin
      if (a_inf && b_inf && (a[63] != b[63])) begin
        spec_val = DEFAULT_NAN;
      end else if (a_inf) begin
        spec_val = a;
      end else if (b_inf) begin
        spec_val = b;
      end else begin
        special = 1'b0;
      end
    end
  end

  // Add operand swap: larger magnitude first
  logic        a_big;
  logic [10:0] big_e, small_e;
  logic [63:0] big_m, sm_m;

  always_comb begin
    a_big   = (a[62:0] >= b[62:0]);
    big_e   = a_big ? ea : eb;
    small_e = a_big ? eb : ea;
    big_m   = a_big ? {1'b0, (a[62:52] != '0), a[51:0], 10'b0}
                    : {1'b0, (b[62:52] != '0), b[51:0], 10'b0};
    sm_m    = a_big ? {1'b0, (b[62:52] != '0), b[51:0], 10'b0}
                    : {1'b0, (a[62:52] != '0), a[51:0], 10'b0};
  end

  // One 27x27 partial product per cycle
  logic [26:0]  pa, pb;
  logic [53:0]  pp;
  logic [6:0]   pp_sh;
  logic [105:0] acc_next;

  always_comb begin
    pa       = pp_k[1] ? {1'b0, sig_a[52:27]} : sig_a[26:0];
    pb       = pp_k[0] ? {1'b0, sig_b[52:27]} : sig_b[26:0];
    pp       = pa * pb;
    pp_sh    = (pp_k[1] ? 7'd27 : 7'd0) + (pp_k[0] ? 7'd27 : 7'd0);
    acc_next = w + (106'(pp) << pp_sh);
  end

  // Alignment and significand add or subtract
  logic [63:0] sm_sh, sm_j, sum_m;
  logic        sm_st;

  always_comb begin
    if (dsh >= 11'd64) begin
      sm_sh = '0;
      sm_st = |small_m;
    end else begin
      sm_sh = small_m >> dsh[5:0];
      sm_st = |(small_m & ~({64{1'b1}} << dsh[5:0]));
    end
    sm_j  = sm_sh | {63'b0, sm_st};
    sum_m = sub ? (w[105:42] - sm_j) : (w[105:42] + sm_j);
  end

  // Denormalizing right shift
  logic signed [13:0] rsh;
  logic [63:0]        man_r;
  logic               st_all, st_r;

  always_comb begin
    st_all = stk | (|w[41:0]);
    rsh    = 14'sd1 - be;
    man_r  = w[105:42];
    st_r   = st_all;
    if (be < 14'sd1) begin
      if (rsh >= 14'sd64) begin
        man_r = '0;
        st_r  = st_all | (|w[105:42]);
      end else begin
        man_r = w[105:42] >> rsh[5:0];
        st_r  = st_all | (|(w[105:42] & ~({64{1'b1}} << rsh[5:0])));
      end
    end
  end

  // Round to nearest even and pack
  logic               rb, sb, inc;
  logic [53:0]        m54;
  logic signed [13:0] e_r;
  logic [51:0]        frac_r;
  logic [63:0]        rnd;

  always_comb begin
    rb  = w[52];
    sb  = stk | (|w[51:0]);
    inc = rb & (sb | w[53]);
    m54 = {1'b0, w[105:53]} + 54'(inc);
    if (m54[53]) begin
      e_r    = be + 14'sd1;
      frac_r = '0;
    end else begin
      e_r    = m54[52] ? be : 14'sd0;
      frac_r = m54[51:0];
    end
    if (e_r >= 14'sd2047) begin
      rnd = {sgn, EXP_MAX, 52'b0};
    end else begin
      rnd = {sgn, e_r[10:0], frac_r};
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      F_IDLE: begin
        if (start) begin
          if (special) begin
            st_next = F_DONE;
          end else if (op == FP_MUL) begin
            st_next = F_MUL;
          end else begin
            st_next = F_ALIGN;
          end
        end
      end
      F_MUL: begin
        if (pp_k == 2'd3) begin
          st_next = F_LNORM;
        end
      end
      F_ALIGN: st_next = F_LNORM;
      F_LNORM: begin
        if (w == '0) begin
          st_next = F_ROUND;
        end else if (w[105]) begin
          st_next = F_RSH;
        end
      end
      F_RSH:   st_next = F_ROUND;
      F_ROUND: st_next = F_DONE;
      F_DONE:  st_next = F_IDLE;
      default: st_next = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (st == F_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (st)
      F_IDLE: begin
        if (start) begin
          result <= spec_val;
          stk    <= 1'b0;
          pp_k   <= 2'd0;
          if (op == FP_MUL) begin
            sgn   <= a[63] ^ b[63];
            be    <= 14'(ea) + 14'(eb) - 14'sd1022;
            sig_a <= {(a[62:52] != '0), a[51:0]};
            sig_b <= {(b[62:52] != '0), b[51:0]};
            w     <= '0;
          end else begin
            sgn     <= a_big ? a[63] : b[63];
            sub     <= a[63] ^ b[63];
            be      <= 14'(big_e) + 14'sd1;
            dsh     <= big_e - small_e;
            small_m <= sm_m;
            w       <= {big_m, 42'b0};
          end
        end
      end
      F_MUL: begin
        w    <= acc_next;
        pp_k <= pp_k + 2'd1;
      end
      F_ALIGN: begin
        w <= {sum_m, 42'b0};
        if (sub && (sum_m == '0)) begin
          sgn <= 1'b0;
        end
      end
      F_LNORM: begin
        if (w != '0 && !w[105]) begin
          if (w[105:90] == '0) begin
            w  <= w << 16;
            be <= be - 14'sd16;
          end else begin
            w  <= w << 1;
            be <= be - 14'sd1;
          end
        end
      end
      F_RSH: begin
        w   <= {man_r, 42'b0};
        stk <= st_r;
        if (be < 14'sd1) begin
          be <= 14'sd1;
        end
      end
      F_ROUND: result <= rnd;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/spgemm_hash_accumulator_unit.sv
// Top level: sparse column hash accumulator with APB configuration.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  -------------------------
//  input     mode row_index a_value b_value               start & !busy
//  result    out_row out_sum is_entry entry_count          strobe, one cycle, no stall
//            overflow_seen last
//  config    psel penable pwrite paddr pwdata prdata       psel & penable & pready
//
// A product beat keeps busy high while it is multiplied and placed. The FP multiply
// takes four 27x27 partial products, normalize, right shift, round and a done state
// (special operands go straight to done, denormal inputs normalize longer), then one
// probe. Each occupied slot adds a compare and, on a miss, another probe; a hit adds
// an FP add (align, normalize, right shift, round, done), longer on long cancellation.
// An end-of-column beat scans every slot through the table memory read port once per
// emitted entry, then emits the smallest untaken row; a marker or count result leaves
// in the cycle after the beat and busy stays low.
// Reset (rst, synchronous) clears valid bits, count, flag and registers to 0,6,0.
// busy is high while a beat is at work; results cannot be held off.
module spgemm_hash_accumulator_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ROW_BITS      = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode,
  input  logic [31:0]                      row_index,
  input  logic [63:0]                      a_value,
  input  logic [63:0]                      b_value,
  output logic                             strobe,
  output logic [31:0]                      out_row,
  output logic [63:0]                      out_sum,
  output logic                             is_entry,
  output logic [6:0]                       entry_count,
  output logic                             overflow_seen,
  output logic                             last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [shacc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import shacc_pkg::*;

  localparam int IW    = $clog2(TABLE_ENTRIES);
  localparam int LGMAX = $clog2(TABLE_ENTRIES + 1) - 1;
  localparam int SW    = LGMAX + 1;
  localparam int RW    = (ROW_BITS < 32) ? ROW_BITS : 32;
  localparam int DW    = RW + 64;

  // Configuration registers
  logic       direct_mode;
  logic [2:0] size_log2;
  logic       count_only;
  logic       cfg_wr, cfg_hit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_hit = cfg_wr && (paddr[3:2] == REG_DIRECT || paddr[3:2] == REG_SIZE_LOG2 ||
                              paddr[3:2] == REG_COUNT_ONLY);

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_mode <= 1'b0;
      size_log2   <= 3'd6;
      count_only  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DIRECT:     direct_mode <= pwdata[0];
        REG_SIZE_LOG2:  size_log2   <= pwdata[2:0];
        REG_COUNT_ONLY: count_only  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIRECT:     prdata = {31'b0, direct_mode};
      REG_SIZE_LOG2:  prdata = {29'b0, size_log2};
      REG_COUNT_ONLY: prdata = {31'b0, count_only};
      default:        prdata = '0;
    endcase
  end

  // Table size and slot mask
  logic [2:0]    lg, lg_eff;
  logic [SW-1:0] size;
  logic [IW-1:0] mask;

  always_comb begin
    lg     = (size_log2 == 3'd0) ? 3'd1 : size_log2;
    lg_eff = (32'(lg) > LGMAX) ? 3'(LGMAX) : lg;
    size   = SW'(1) << lg_eff;
    mask   = IW'(size - SW'(1));
  end

  // Controller state and datapath registers
  ctl_state_t        state, state_next;
  logic [RW-1:0]     row_q;
  logic [63:0]       prod_q;
  logic [IW-1:0]     slot;
  logic [SW-1:0]     tries;
  logic [SW-1:0]     count;
  logic              drop_flag;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] taken;
  logic [IW-1:0]     scan_idx;
  logic              scan_end;
  logic              p_act, p_vld, p_last;
  logic [IW-1:0]     p_slot;
  logic              best_found;
  logic [RW-1:0]     best_row;
  logic [63:0]       best_sum;
  logic [IW-1:0]     best_slot;
  logic [SW-1:0]     emitted;

  // Memory and FP unit hookup
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [RW-1:0] rd_row;
  logic [63:0]   rd_sum;
  logic          fpu_start, fpu_done;
  fp_op_t        fpu_op;
  logic [63:0]   fpu_a, fpu_b, fpu_res;

  assign rd_row = mem_rdata[DW-1:64];
  assign rd_sum = mem_rdata[63:0];

  shacc_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  shacc_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .op     (fpu_op),
    .a      (fpu_a),
    .b      (fpu_b),
    .done   (fpu_done),
    .result (fpu_res)
  );

  // Home slot and probe helpers
  logic [63:0]   row_ext;
  logic [IW+6:0] hprod;
  logic [IW-1:0] home;
  logic          direct_oor;
  logic          hit;
  logic [SW-1:0] tries_n;
  logic          accept, marker, scan_last, emit_last, dense;
  logic [63:0]   emit_sum;

  always_comb begin
    row_ext    = 64'(row_q);
    hprod      = (IW + 7)'(row_ext[IW-1:0]) * (IW + 7)'(HASH_MULT);
    home       = direct_mode ? row_ext[IW-1:0] : (hprod[IW-1:0] & mask);
    direct_oor = direct_mode && (row_ext >= 64'(size));
    hit        = (rd_row == row_q);
    tries_n    = tries + SW'(1);
    accept     = start && !busy;
    marker     = count_only || (count == '0);
    scan_last  = (scan_idx == IW'(size - SW'(1)));
    emit_last  = ((emitted + SW'(1)) == count);
    dense      = direct_mode && (count == size);
    emit_sum   = (dense && best_sum == NEG_ZERO) ? 64'd0 : best_sum;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (accept) begin
          if (!mode) begin
            state_next = C_MUL;
          end else if (!marker) begin
            state_next = C_SCAN;
          end
        end
      end
      C_MUL: begin
        if (fpu_done) begin
          state_next = direct_oor ? C_IDLE : C_PROBE;
        end
      end
      C_PROBE: state_next = valid[slot] ? C_CMP : C_IDLE;
      C_CMP: begin
        if (hit) begin
          state_next = C_ADD;
        end else if (tries_n == size) begin
          state_next = C_IDLE;
        end else begin
          state_next = C_PROBE;
        end
      end
      C_ADD: begin
        if (fpu_done) begin
          state_next = C_IDLE;
        end
      end
      C_SCAN: begin
        if (p_act && p_last) begin
          state_next = C_EMIT;
        end
      end
      C_EMIT:  state_next = emit_last ? C_IDLE : C_SCAN;
      default: state_next = C_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy      = (state != C_IDLE);
    fpu_start = 1'b0;
    fpu_op    = FP_MUL;
    fpu_a     = a_value;
    fpu_b     = b_value;
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = {row_q, prod_q};
    mem_raddr = slot;
    case (state)
      C_IDLE: begin
        fpu_start = accept && !mode;
      end
      C_PROBE: begin
        mem_we = !valid[slot];
      end
      C_CMP: begin
        fpu_start = hit;
        fpu_op    = FP_ADD;
        fpu_a     = rd_sum;
        fpu_b     = prod_q;
      end
      C_ADD: begin
        mem_we    = fpu_done;
        mem_wdata = {row_q, fpu_res};
      end
      C_SCAN: begin
        mem_raddr = scan_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Column bookkeeping: valid bits, count, drop flag, selection scan
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      taken     <= '0;
      count     <= '0;
      drop_flag <= 1'b0;
      emitted   <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_hit) begin
        valid     <= '0;
        taken     <= '0;
        count     <= '0;
        drop_flag <= 1'b0;
        emitted   <= '0;
      end
      case (state)
        C_IDLE: begin
          if (accept) begin
            row_q      <= RW'(row_index);
            scan_idx   <= '0;
            scan_end   <= 1'b0;
            p_act      <= 1'b0;
            best_found <= 1'b0;
            if (mode && marker) begin
              // marker or count result, then drop the column
              strobe        <= 1'b1;
              out_row       <= '0;
              out_sum       <= '0;
              is_entry      <= 1'b0;
              entry_count   <= count_only ? 7'(count) : 7'd0;
              overflow_seen <= drop_flag;
              last          <= 1'b1;
              valid         <= '0;
              count         <= '0;
              drop_flag     <= 1'b0;
            end
          end
        end
        C_MUL: begin
          if (fpu_done) begin
            prod_q <= fpu_res;
            slot   <= home;
            tries  <= '0;
            if (direct_oor) begin
              drop_flag <= 1'b1;
            end
          end
        end
        C_PROBE: begin
          if (!valid[slot]) begin
            valid[slot] <= 1'b1;
            count       <= count + SW'(1);
          end
        end
        C_CMP: begin
          if (!hit) begin
            tries <= tries_n;
            slot  <= (slot + IW'(1)) & mask;
            if (tries_n == size) begin
              drop_flag <= 1'b1;
            end
          end
        end
        C_SCAN: begin
          // issue one slot read per cycle
          p_act <= !scan_end;
          if (!scan_end) begin
            p_vld    <= valid[scan_idx] && !taken[scan_idx];
            p_slot   <= scan_idx;
            p_last   <= scan_last;
            scan_idx <= scan_idx + IW'(1);
            scan_end <= scan_last;
          end
          // keep the smallest untaken row
          if (p_act && p_vld && (!best_found || rd_row < best_row)) begin
            best_found <= 1'b1;
            best_row   <= rd_row;
            best_sum   <= rd_sum;
            best_slot  <= p_slot;
          end
        end
        C_EMIT: begin
          strobe           <= 1'b1;
          out_row          <= 32'(best_row);
          out_sum          <= emit_sum;
          is_entry         <= 1'b1;
          entry_count      <= 7'(count);
          overflow_seen    <= drop_flag;
          last             <= emit_last;
          taken[best_slot] <= 1'b1;
          emitted          <= emitted + SW'(1);
          scan_idx         <= '0;
          scan_end         <= 1'b0;
          p_act            <= 1'b0;
          best_found       <= 1'b0;
          if (emit_last) begin
            valid     <= '0;
            taken     <= '0;
            count     <= '0;
            drop_flag <= 1'b0;
            emitted   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`include "spgemm_hash_accumulator_unit_assert.svh"

  `SHACC_ASSERT_IMP(a_count_bound, 1'b1, count <= size)
  `SHACC_ASSERT_IMP(a_emit_found, state == C_EMIT, best_found)
  `SHACC_ASSERT_IMP(a_write_in_range, mem_we, 32'(mem_waddr) < 32'(size))
  `SHACC_ASSERT_IMP(a_last_clears, strobe && last, count == '0 && !drop_flag)
  `SHACC_ASSERT_NXT(a_hit_adds, state == C_CMP && hit, state == C_ADD)

endmodule

// File: dv/tb_spgemm_hash_accumulator_unit.sv
// Self-checking testbench for the sparse column hash accumulator.
module tb_spgemm_hash_accumulator_unit;
  import shacc_pkg::*;

  typedef struct {
    logic        mode;
    logic [31:0] row;
    logic [63:0] a;
    logic [63:0] b;
  } product_beat_t;

  typedef struct {
    logic [31:0] row;
    logic [63:0] sum;
    logic        is_entry;
    logic [6:0]  count;
    logic        ovf;
    logic        last;
  } column_entry_t;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] LG_PICK [8] = '{3'd6, 3'd1, 3'd3, 3'd0, 3'd7, 3'd2, 3'd4, 3'd5};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic mode = 1'b0;
  logic [31:0] row_index = '0;
  logic [63:0] a_value = '0;
  logic [63:0] b_value = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, strobe, is_entry, overflow_seen, last, pready;
  logic [31:0] out_row, prdata;
  logic [63:0] out_sum;
  logic [6:0] entry_count;

  spgemm_hash_accumulator_unit uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state of the accumulator
  logic        m_direct = 1'b0;
  logic [2:0]  m_log2 = 3'd6;
  logic        m_count_only = 1'b0;
  logic        m_valid [DEPTH];
  logic [31:0] m_row [DEPTH];
  logic [63:0] m_sum [DEPTH];
  int          m_distinct = 0;
  logic        m_drop = 1'b0;

  product_beat_t pending_beats[$];
  column_entry_t expected_entries[$];
  product_beat_t cur_beat;
  bit beat_taken = 0;
  bit no_gaps = 0;
  int gap_left = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  function automatic int table_entries();
    int lg;
    int sz;
    lg = (m_log2 == 0) ? 1 : m_log2;
    sz = 1 << lg;
    while (sz > DEPTH) sz = sz >> 1;
    return sz;
  endfunction

  function automatic void clear_column();
    for (int i = 0; i < DEPTH; i++) m_valid[i] = 1'b0;
    m_distinct = 0;
    m_drop = 1'b0;
  endfunction

  function automatic void insert_product(logic [31:0] r, real t);
    int sz;
    int slot;
    longint unsigned h;
    sz = table_entries();
    if (m_direct) begin
      if (r >= sz) begin
        m_drop = 1'b1;
        return;
      end
      slot = r;
      if (m_valid[slot]) begin
        m_sum[slot] = $realtobits($bitstoreal(m_sum[slot]) + t);
      end else begin
        m_valid[slot] = 1'b1;
        m_row[slot] = r;
        m_sum[slot] = $realtobits(t);
        m_distinct++;
      end
      return;
    end
    h = longint'(r) * 107;
    slot = int'(h & (sz - 1));
    for (int k = 0; k < sz; k++) begin
      if (!m_valid[slot]) begin
        m_valid[slot] = 1'b1;
        m_row[slot] = r;
        m_sum[slot] = $realtobits(t);
        m_distinct++;
        return;
      end
      if (m_row[slot] == r) begin
        m_sum[slot] = $realtobits($bitstoreal(m_sum[slot]) + t);
        return;
      end
      slot = (slot + 1) & (sz - 1);
    end
    m_drop = 1'b1;
  endfunction

  // Work out the results of one accepted beat
  function automatic void absorb_beat(product_beat_t bt);
    int order[DEPTH];
    int n;
    int j;
    bit dense;
    column_entry_t e;
    n = 0;
    if (!bt.mode) begin
      insert_product(bt.row, $bitstoreal(bt.a) * $bitstoreal(bt.b));
      return;
    end
    dense = m_direct && (m_distinct == table_entries());
    if (m_count_only || m_distinct == 0) begin
      e.row = '0;
      e.sum = '0;
      e.is_entry = 1'b0;
      e.count = m_count_only ? m_distinct[6:0] : 7'd0;
      e.ovf = m_drop;
      e.last = 1'b1;
      expected_entries.push_back(e);
      clear_column();
      return;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (m_valid[i]) begin
        j = n;
        while (j > 0 && m_row[order[j-1]] > m_row[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      e.row = m_row[order[i]];
      e.sum = m_sum[order[i]];
      if (dense && e.sum == NEG_ZERO) e.sum = '0;
      e.is_entry = 1'b1;
      e.count = m_distinct[6:0];
      e.ovf = m_drop;
      e.last = (i == n - 1);
      expected_entries.push_back(e);
    end
    clear_column();
  endfunction

  // Drive beats at the falling edge, with random gaps unless no_gaps is set
  always @(negedge clk) begin
    if (!rst && !(start && !beat_taken)) begin
      beat_taken = 0;
      if (gap_left > 0 || pending_beats.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        cur_beat = pending_beats.pop_front();
        mode <= cur_beat.mode;
        row_index <= cur_beat.row;
        a_value <= cur_beat.a;
        b_value <= cur_beat.b;
        start <= 1'b1;
        if (!no_gaps) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7, 8: gap_left = $urandom_range(1, 3);
            default: gap_left = $urandom_range(10, 40);
          endcase
        end
      end
    end
  end

  // Accept beats and check results at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      stall_cycles++;
      if (start && !busy && !beat_taken) begin
        absorb_beat(cur_beat);
        beat_taken = 1;
        stall_cycles = 0;
      end
      if (strobe) begin
        stall_cycles = 0;
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result row=%h sum=%h", out_row, out_sum);
        end else begin
          column_entry_t e;
          e = expected_entries.pop_front();
          if (e.row !== out_row || e.sum !== out_sum || e.is_entry !== is_entry ||
              e.count !== entry_count || e.ovf !== overflow_seen || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp row=%h sum=%h ent=%b cnt=%0d ovf=%b last=%b / got %h %h %b %0d %b %b",
                       e.row, e.sum, e.is_entry, e.count, e.ovf, e.last,
                       out_row, out_sum, is_entry, entry_count, overflow_seen, last);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_spgemm_hash_accumulator_unit: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_ADDR_W'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DIRECT: m_direct = val[0];
      REG_SIZE_LOG2: m_log2 = val[2:0];
      default: m_count_only = val[0];
    endcase
    clear_column();
    stall_cycles = 0;
  endtask

  task automatic configure(logic d, logic [2:0] lg, logic co);
    write_reg(REG_DIRECT, 32'(d));
    write_reg(REG_SIZE_LOG2, 32'(lg));
    write_reg(REG_COUNT_ONLY, 32'(co));
  endtask

  // Hold until every beat is taken and every result has arrived
  task automatic drain();
    while (pending_beats.size() != 0 || start || expected_entries.size() != 0)
      @(negedge clk);
    while (busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic void push_beat(logic md, logic [31:0] r, logic [63:0] a, logic [63:0] b);
    product_beat_t bt;
    bt.mode = md;
    bt.row = r;
    bt.a = a;
    bt.b = b;
    pending_beats.push_back(bt);
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v[51:0] = 52'({$urandom(), $urandom()});
    v[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
    v[63] = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 29))
      0: v = '0;
      1: v = NEG_ZERO;
      2: v = {v[63], 11'h7FE, 52'hF_FFFF_FFFF_FFFF};
      3: v = {v[63], 11'h000, v[51:0]};
      default: ;
    endcase
    return v;
  endfunction

  // One column of random products, rows mostly drawn from a pool sized to the table, then an end-of-column beat
  function automatic void random_column(int nprod);
    int sz;
    logic [31:0] r;
    sz = table_entries();
    for (int i = 0; i < nprod; i++) begin
      case ($urandom_range(0, 9))
        0: r = $urandom();
        1: r = sz + $urandom_range(0, 3);
        default: r = m_direct ? $urandom_range(0, sz - 1) : $urandom_range(0, sz + 2) * 37;
      endcase
      push_beat(1'b0, r, rand_double(), rand_double());
    end
    push_beat(1'b1, $urandom(), {$urandom(), $urandom()}, {$urandom(), $urandom()});
  endfunction

  initial begin
    int budget;
    int ph;
    for (int i = 0; i < DEPTH; i++) m_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty column, repeated rows, extreme values, default settings
    push_beat(1'b1, 32'd0, '0, '0);
    push_beat(1'b0, 32'hFFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
    push_beat(1'b0, 32'd0, 64'h7FF0_0000_0000_0000, '0);
    push_beat(1'b0, 32'hFFFF_FFFF, 64'hBFF8_0000_0000_0000, 64'h4010_0000_0000_0000);
    push_beat(1'b0, 32'd5, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000);
    push_beat(1'b0, 32'd6, 64'h0000_0000_0000_0001, 64'hC000_0000_0000_0000);
    push_beat(1'b0, 32'd5, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000);
    push_beat(1'b1, 32'hFFFF_FFFF, '1, '1);
    drain();

    // Direct, two slots: dense column of negative zeros, then an out of range row
    configure(1'b1, 3'd1, 1'b0);
    push_beat(1'b0, 32'd0, NEG_ZERO, 64'h3FF0_0000_0000_0000);
    push_beat(1'b0, 32'd1, 64'h3FF0_0000_0000_0000, NEG_ZERO);
    push_beat(1'b1, 32'd0, '0, '0);
    push_beat(1'b0, 32'd0, NEG_ZERO, 64'h3FF0_0000_0000_0000);
    push_beat(1'b0, 32'd2, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_beat(1'b1, 32'd0, '0, '0);
    drain();

    // Hash, two slots: full table drops the third row; count only, then with entries
    configure(1'b0, 3'd1, 1'b1);
    push_beat(1'b0, 32'd3, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_beat(1'b0, 32'd4, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_beat(1'b0, 32'd9, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_beat(1'b1, 32'd0, '0, '0);
    drain();
    write_reg(REG_COUNT_ONLY, 32'd0);
    push_beat(1'b0, 32'd3, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_beat(1'b0, 32'd4, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_beat(1'b0, 32'd9, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    push_beat(1'b1, 32'd0, '0, '0);
    drain();

    // Random phases across table sizes, modes and count only
    budget = 185;
    ph = 0;
    while (budget > 0) begin
      configure(1'($urandom_range(0, 1)), LG_PICK[ph % 8], ($urandom_range(0, 3) == 0));
      no_gaps = (ph % 4 == 3);
      for (int c = 0; c < 3 && budget > 0; c++) begin
        int np;
        np = (c == 0 && ph % 3 == 0) ? 0 : $urandom_range(1, 12);
        if (ph % 8 == 7 && c == 0) np = 60;
        random_column(np);
        budget -= np + 1;
      end
      drain();
      ph++;
    end

    if (mismatches == 0 && expected_entries.size() == 0)
      $display("tb_spgemm_hash_accumulator_unit: clean");
    else
      $display("tb_spgemm_hash_accumulator_unit: errors");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/shacc_pkg.sv
hw/rtl/shacc_table.sv
hw/rtl/shacc_fpu.sv
hw/rtl/spgemm_hash_accumulator_unit.sv
dv/tb_spgemm_hash_accumulator_unit.sv
